@@ rtl/srrq_pkg.sv @@
// Shared constants, types and slot arithmetic for the shortest-remaining ready queue.
package srrq_pkg;

    localparam int DEPTH    = 128;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 16;
    localparam int POS_W    = 7;
    localparam int OCNT_W   = 8;

    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int OWIDE_W  = (OCNT_W > CNT_W) ? OCNT_W : CNT_W;

    localparam int S_DATA_BITS = ID_W + TIME_W + POS_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ID_W + TIME_W + POS_W + OCNT_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_ENQ = 2'd0,
        K_DEQ = 2'd1,
        K_MIN = 2'd2,
        K_REM = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] rtime;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] ofs);
        localparam logic [ADDR_W:0] DEPTH_WRAP = (ADDR_W + 1)'(DEPTH);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_WRAP) begin
            sum = sum - DEPTH_WRAP;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/srrq_store.sv @@
// Entry memory: one write port, one registered read port.
module srrq_store (
    input  logic              aclk,
    input  srrq_pkg::mem_wr_t wr,
    input  srrq_pkg::mem_rd_t rd,
    output srrq_pkg::entry_t  rd_data
);

    srrq_pkg::entry_t mem [srrq_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ rtl/shortest_remaining_ready_queue.sv @@
// Shortest-remaining-time ready queue: ring buffer in memory with min scan and ordered removal.
//
//  channel | dir | tuser          | tdata (lowest bit up)
//  s_      | in  | kind           | process_id, remaining_time, position
//  m_      | out | status         | found_id, found_time, found_position, entry_count
//
//  Enqueue and error results pass through the result registers and S_DONE to the output register.
//  Find-min reads the entry memory once per cycle over all entries.
//  In remove-at and dequeue, each moved entry is read and written back
//  one slot later, pipelined through the single read and single write port.
//  Reset needs no clearing pass; head and count clear at once.
//  A finished result waits in the output register while the next transaction is accepted;
//  a stalled m_ side holds only the completion of the following one.
module shortest_remaining_ready_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srrq_pkg::S_TDATA_W-1:0] s_tdata,  // process_id, remaining_time, position
    input  logic [srrq_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srrq_pkg::M_TDATA_W-1:0] m_tdata,  // found_id, found_time, found_position,
                                                      // entry_count
    output logic [srrq_pkg::STATUS_W-1:0]  m_tuser   // status
);

    localparam int ADDR_W = srrq_pkg::ADDR_W;
    localparam int CNT_W  = srrq_pkg::CNT_W;
    localparam int ID_W   = srrq_pkg::ID_W;
    localparam int TIME_W = srrq_pkg::TIME_W;
    localparam int POS_W  = srrq_pkg::POS_W;
    localparam int CMP_W  = srrq_pkg::CMP_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] tgt_reg, tgt_next;
    logic [ADDR_W-1:0] iss_idx_reg, iss_idx_next;
    logic              iss_on_reg, iss_on_next;
    logic              ret_on_reg, ret_on_next;
    logic [ADDR_W-1:0] ret_idx_reg, ret_idx_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [TIME_W-1:0] best_time_reg, best_time_next;
    logic [ADDR_W-1:0] best_pos_reg, best_pos_next;
    srrq_pkg::status_t res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [TIME_W-1:0] res_time_reg, res_time_next;
    logic [ADDR_W-1:0] res_pos_reg, res_pos_next;
    logic [CNT_W-1:0]  res_count_reg, res_count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [srrq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [srrq_pkg::STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    srrq_pkg::mem_wr_t wr;
    srrq_pkg::mem_rd_t rd;
    srrq_pkg::entry_t  rd_data;

    srrq_pkg::kind_t   in_kind;
    logic [ID_W-1:0]   in_pid;
    logic [TIME_W-1:0] in_rtime;
    logic [POS_W-1:0]  in_pos;

    logic                        out_free;
    logic                        cand_better;
    logic [CMP_W-1:0]            pos_wide;
    logic [srrq_pkg::OWIDE_W-1:0] count_wide;

    srrq_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign in_kind  = srrq_pkg::kind_t'(s_tuser);
    assign in_pid   = s_tdata[ID_W-1:0];
    assign in_rtime = s_tdata[ID_W+TIME_W-1:ID_W];
    assign in_pos   = s_tdata[ID_W+TIME_W+POS_W-1:ID_W+TIME_W];

    assign out_free    = !m_tvalid_reg || m_tready;
    assign cand_better = (ret_idx_reg == '0) || (rd_data.rtime < best_time_reg);
    assign pos_wide    = CMP_W'(res_pos_reg);
    assign count_wide  = srrq_pkg::OWIDE_W'(res_count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        tgt_next        = tgt_reg;
        iss_idx_next    = iss_idx_reg;
        iss_on_next     = iss_on_reg;
        ret_on_next     = 1'b0;
        ret_idx_next    = ret_idx_reg;
        best_id_next    = best_id_reg;
        best_time_next  = best_time_reg;
        best_pos_next   = best_pos_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_time_next   = res_time_reg;
        res_pos_next    = res_pos_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr              = '0;
        rd              = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_status_next = srrq_pkg::ST_OK;
                    res_id_next     = '0;
                    res_time_next   = '0;
                    res_pos_next    = '0;
                    res_count_next  = count_reg;
                    iss_idx_next    = '0;
                    state_next      = S_DONE;
                    if (in_kind == srrq_pkg::K_ENQ) begin
                        if (count_reg == CNT_W'(srrq_pkg::DEPTH)) begin
                            res_status_next = srrq_pkg::ST_FULL;
                        end else begin
                            wr.en          = 1'b1;
                            wr.addr        = srrq_pkg::slot_of(head_reg, ADDR_W'(count_reg));
                            wr.data.pid    = in_pid;
                            wr.data.rtime  = in_rtime;
                            count_next     = count_reg + 1'b1;
                            res_count_next = count_reg + 1'b1;
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = srrq_pkg::ST_EMPTY;
                    end else begin
                        unique case (in_kind)
                            srrq_pkg::K_DEQ: begin
                                tgt_next    = '0;
                                iss_on_next = 1'b1;
                                state_next  = S_SHIFT;
                            end
                            srrq_pkg::K_MIN: begin
                                tgt_next    = ADDR_W'(count_reg - 1'b1);
                                iss_on_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                            srrq_pkg::K_REM: begin
                                if (CMP_W'(in_pos) >= CMP_W'(count_reg)) begin
                                    res_status_next = srrq_pkg::ST_BADPOS;
                                end else begin
                                    tgt_next     = ADDR_W'(in_pos);
                                    iss_idx_next = ADDR_W'(in_pos);
                                    iss_on_next  = 1'b1;
                                    state_next   = S_SHIFT;
                                end
                            end
                            default: begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (iss_on_reg) begin
                    rd.en        = 1'b1;
                    rd.addr      = srrq_pkg::slot_of(head_reg, iss_idx_reg);
                    ret_on_next  = 1'b1;
                    ret_idx_next = iss_idx_reg;
                    if (iss_idx_reg == tgt_reg) begin
                        iss_on_next = 1'b0;
                    end else begin
                        iss_idx_next = iss_idx_reg + 1'b1;
                    end
                end
                if (ret_on_reg) begin
                    if (cand_better) begin
                        best_id_next   = rd_data.pid;
                        best_time_next = rd_data.rtime;
                        best_pos_next  = ret_idx_reg;
                    end
                    if (ret_idx_reg == tgt_reg) begin
                        res_status_next = srrq_pkg::ST_OK;
                        res_id_next     = cand_better ? rd_data.pid : best_id_reg;
                        res_time_next   = cand_better ? rd_data.rtime : best_time_reg;
                        res_pos_next    = cand_better ? ret_idx_reg : best_pos_reg;
                        res_count_next  = count_reg;
                        state_next      = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (iss_on_reg) begin
                    rd.en        = 1'b1;
                    rd.addr      = srrq_pkg::slot_of(head_reg, iss_idx_reg);
                    ret_on_next  = 1'b1;
                    ret_idx_next = iss_idx_reg;
                    if (iss_idx_reg == '0) begin
                        iss_on_next = 1'b0;
                    end else begin
                        iss_idx_next = iss_idx_reg - 1'b1;
                    end
                end
                if (ret_on_reg) begin
                    if (ret_idx_reg == tgt_reg) begin
                        best_id_next   = rd_data.pid;
                        best_time_next = rd_data.rtime;
                    end else begin
                        wr.en   = 1'b1;
                        wr.addr = srrq_pkg::slot_of(head_reg, ret_idx_reg + 1'b1);
                        wr.data = rd_data;
                    end
                    if (ret_idx_reg == '0) begin
                        head_next       = srrq_pkg::slot_of(head_reg, ADDR_W'(1));
                        count_next      = count_reg - 1'b1;
                        res_status_next = srrq_pkg::ST_OK;
                        res_id_next     = (tgt_reg == '0) ? rd_data.pid : best_id_reg;
                        res_time_next   = (tgt_reg == '0) ? rd_data.rtime : best_time_reg;
                        res_pos_next    = tgt_reg;
                        res_count_next  = count_reg - 1'b1;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = srrq_pkg::M_TDATA_W'({count_wide[srrq_pkg::OCNT_W-1:0],
                                                          pos_wide[POS_W-1:0],
                                                          res_time_reg,
                                                          res_id_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            iss_on_reg   <= 1'b0;
            ret_on_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            iss_on_reg   <= iss_on_next;
            ret_on_reg   <= ret_on_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg        <= tgt_next;
        iss_idx_reg    <= iss_idx_next;
        ret_idx_reg    <= ret_idx_next;
        best_id_reg    <= best_id_next;
        best_time_reg  <= best_time_next;
        best_pos_reg   <= best_pos_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_time_reg   <= res_time_next;
        res_pos_reg    <= res_pos_next;
        res_count_reg  <= res_count_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(srrq_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("read and write hit the same slot in one cycle");

    a_read_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd.en |-> (state_reg == S_SCAN || state_reg == S_SHIFT))
        else $error("memory read outside a scan or shift");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    a_return_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd.en |=> ret_on_reg)
        else $error("read data return not tracked");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the shortest-remaining-time ready queue.
module testbench;

    typedef struct packed {
        srrq_pkg::status_t                status;
        logic [srrq_pkg::ID_W-1:0]        found_id;
        logic [srrq_pkg::TIME_W-1:0]      found_time;
        logic [srrq_pkg::POS_W-1:0]       found_pos;
        logic [srrq_pkg::OCNT_W-1:0]      count;
    } outcome_t;

    class srtf_scoreboard;
        srrq_pkg::entry_t ready_list[$];
        outcome_t         awaited[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      kind_seen[4];
        int unsigned      status_seen[4];

        function int unsigned held();
            return ready_list.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void record_request(srrq_pkg::kind_t op,
                                     logic [srrq_pkg::ID_W-1:0] pid,
                                     logic [srrq_pkg::TIME_W-1:0] rtime,
                                     logic [srrq_pkg::POS_W-1:0] pos);
            outcome_t         o;
            srrq_pkg::entry_t e;
            int unsigned      best;
            o = '0;
            o.status = srrq_pkg::ST_OK;
            e.pid = pid;
            e.rtime = rtime;
            if (op == srrq_pkg::K_ENQ) begin
                if (ready_list.size() >= srrq_pkg::DEPTH) begin
                    o.status = srrq_pkg::ST_FULL;
                end else begin
                    ready_list.push_back(e);
                end
            end else if (ready_list.size() == 0) begin
                o.status = srrq_pkg::ST_EMPTY;
            end else begin
                case (op)
                    srrq_pkg::K_DEQ: begin
                        e = ready_list.pop_front();
                        o.found_id = e.pid;
                        o.found_time = e.rtime;
                    end
                    srrq_pkg::K_MIN: begin
                        best = 0;
                        for (int i = 1; i < ready_list.size(); i++) begin
                            if (ready_list[i].rtime < ready_list[best].rtime) begin
                                best = i;
                            end
                        end
                        o.found_id = ready_list[best].pid;
                        o.found_time = ready_list[best].rtime;
                        o.found_pos = srrq_pkg::POS_W'(best);
                    end
                    default: begin
                        if (pos >= ready_list.size()) begin
                            o.status = srrq_pkg::ST_BADPOS;
                        end else begin
                            e = ready_list[pos];
                            ready_list.delete(pos);
                            o.found_id = e.pid;
                            o.found_time = e.rtime;
                            o.found_pos = pos;
                        end
                    end
                endcase
            end
            o.count = srrq_pkg::OCNT_W'(ready_list.size());
            kind_seen[op]++;
            status_seen[o.status]++;
            awaited.push_back(o);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                         $time, checked, name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(logic [srrq_pkg::STATUS_W-1:0] st,
                                    logic [srrq_pkg::M_TDATA_W-1:0] data);
            outcome_t o;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, st, data);
                errors++;
                return;
            end
            o = awaited.pop_front();
            compare_field("status", o.status, st);
            compare_field("found_id", o.found_id, data[15:0]);
            compare_field("found_time", o.found_time, data[31:16]);
            compare_field("found_position", o.found_pos, data[38:32]);
            compare_field("entry_count", o.count, data[46:39]);
            checked++;
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [srrq_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [srrq_pkg::KIND_W-1:0]      s_tuser = srrq_pkg::K_ENQ;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [srrq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [srrq_pkg::STATUS_W-1:0]    m_tuser;

    srtf_scoreboard board = new();
    bit             gaps_on = 1'b0;
    bit             hold_request = 1'b0;

    shortest_remaining_ready_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 48);
    endfunction

    task automatic send_item(input srrq_pkg::kind_t op,
                             input logic [srrq_pkg::ID_W-1:0] pid,
                             input logic [srrq_pkg::TIME_W-1:0] rtime,
                             input logic [srrq_pkg::POS_W-1:0] pos);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= srrq_pkg::S_TDATA_W'({pos, rtime, pid});
        s_tuser <= op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        board.record_request(op, pid, rtime, pos);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_outcomes();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned items, input int unsigned enq_pct,
                             input int unsigned hold_at);
        srrq_pkg::kind_t             op;
        logic [srrq_pkg::POS_W-1:0]  pos;
        logic [srrq_pkg::TIME_W-1:0] rtime;
        int unsigned                 cnt;
        for (int n = 0; n < items; n++) begin
            if (hold_at != 0 && n == hold_at) begin
                hold_request = 1'b1;
            end
            cnt = board.held();
            if ($urandom_range(0, 99) < enq_pct) begin
                op = srrq_pkg::K_ENQ;
            end else begin
                case ($urandom_range(0, 2))
                    0: op = srrq_pkg::K_DEQ;
                    1: op = srrq_pkg::K_MIN;
                    default: op = srrq_pkg::K_REM;
                endcase
            end
            if (cnt > 0 && $urandom_range(0, 9) < 8) begin
                pos = srrq_pkg::POS_W'($urandom_range(0, cnt - 1));
            end else begin
                pos = srrq_pkg::POS_W'($urandom_range(0, 127));
            end
            if ($urandom_range(0, 9) < 3) begin
                rtime = srrq_pkg::TIME_W'($urandom_range(0, 7));
            end else begin
                rtime = srrq_pkg::TIME_W'($urandom);
            end
            send_item(op, srrq_pkg::ID_W'($urandom), rtime, pos);
        end
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial begin
        int unsigned rx_hold;
        rx_hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_outcome(m_tuser, m_tdata);
            end
            if (rx_hold == 0) begin
                if (hold_request) begin
                    hold_request = 1'b0;
                    rx_hold = 400;
                end else if (gaps_on) begin
                    rx_hold = pick_gap();
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_item(srrq_pkg::K_DEQ, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_item(srrq_pkg::K_MIN, 16'h0000, 16'h0000, 7'h00);
        send_item(srrq_pkg::K_REM, 16'hA5A5, 16'h5A5A, 7'd0);
        send_item(srrq_pkg::K_ENQ, 16'h0000, 16'hFFFF, 7'h7F);
        send_item(srrq_pkg::K_ENQ, 16'hFFFF, 16'h0000, 7'h00);
        send_item(srrq_pkg::K_ENQ, 16'h1234, 16'h0000, 7'h55);
        send_item(srrq_pkg::K_ENQ, 16'h8001, 16'h7FFF, 7'h2A);
        send_item(srrq_pkg::K_MIN, 16'h5A5A, 16'hA5A5, 7'h7F);
        send_item(srrq_pkg::K_REM, 16'h0000, 16'h0000, 7'd4);
        send_item(srrq_pkg::K_REM, 16'hFFFF, 16'hFFFF, 7'd127);
        send_item(srrq_pkg::K_REM, 16'h0000, 16'h0000, 7'd3);
        send_item(srrq_pkg::K_REM, 16'h0000, 16'h0000, 7'd1);
        send_item(srrq_pkg::K_MIN, 16'h0000, 16'h0000, 7'd0);
        send_item(srrq_pkg::K_ENQ, 16'h4321, 16'h0001, 7'd0);
        send_item(srrq_pkg::K_REM, 16'h0000, 16'h0000, 7'd0);
        send_item(srrq_pkg::K_DEQ, 16'h0000, 16'h0000, 7'd0);
        send_item(srrq_pkg::K_MIN, 16'h0000, 16'h0000, 7'd0);
        send_item(srrq_pkg::K_DEQ, 16'h0000, 16'h0000, 7'd0);
        send_item(srrq_pkg::K_DEQ, 16'h0000, 16'h0000, 7'd0);
        wait_for_outcomes();

        gaps_on = 1'b1;
        run_phase(200, 85, 60);
        wait_for_outcomes();
        run_phase(150, 15, 0);
        wait_for_outcomes();
        for (int p = 0; p < 4; p++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            run_phase(85, $urandom_range(30, 70), 0);
            wait_for_outcomes();
        end

        repeat (200) @(posedge aclk);
        $display("Checked %0d results: %0d enqueue, %0d dequeue, %0d find-min, %0d remove-at.",
                 board.checked, board.kind_seen[srrq_pkg::K_ENQ],
                 board.kind_seen[srrq_pkg::K_DEQ], board.kind_seen[srrq_pkg::K_MIN],
                 board.kind_seen[srrq_pkg::K_REM]);
        $display("Status mix: %0d ok, %0d full, %0d empty, %0d bad position; %0d errors.",
                 board.status_seen[srrq_pkg::ST_OK], board.status_seen[srrq_pkg::ST_FULL],
                 board.status_seen[srrq_pkg::ST_EMPTY], board.status_seen[srrq_pkg::ST_BADPOS],
                 board.errors);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
